FILE: hdl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// types, constants and the arctangent table of the sphere vertex generator
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	localparam logic [14:0] LAT_STEP_RST = 15'd2185;
	localparam logic [14:0] LON_STEP_RST = 15'd4096;

	typedef enum logic {
		REG_LAT_STEP = 1'b0,
		REG_LON_STEP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                 vld;
		logic signed [CW-1:0] xa;
		logic signed [CW-1:0] ya;
		logic signed [CW-1:0] za;
		logic                 nega;
		logic signed [CW-1:0] xo;
		logic signed [CW-1:0] yo;
		logic signed [CW-1:0] zo;
		logic                 nego;
		logic [16:0]          u;
	} cordic_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/uvs_cell.sv
// ----------------------------------------------------------------------------
// uvs_cell
// one cordic rotation step for the latitude and longitude lanes
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_cell
	import uvs_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire cordic_t din,
	output cordic_t      dout
);

	localparam logic signed [CW-1:0] ATAN = CW'(atan_turn(STAGE));

	cordic_t nxt;
	cordic_t cell_q;

	always_comb begin
		nxt = din;
		if (din.za >= 0) begin
			nxt.xa = din.xa - (din.ya >>> STAGE);
			nxt.ya = din.ya + (din.xa >>> STAGE);
			nxt.za = din.za - ATAN;
		end else begin
			nxt.xa = din.xa + (din.ya >>> STAGE);
			nxt.ya = din.ya - (din.xa >>> STAGE);
			nxt.za = din.za + ATAN;
		end
		if (din.zo >= 0) begin
			nxt.xo = din.xo - (din.yo >>> STAGE);
			nxt.yo = din.yo + (din.xo >>> STAGE);
			nxt.zo = din.zo - ATAN;
		end else begin
			nxt.xo = din.xo + (din.yo >>> STAGE);
			nxt.yo = din.yo - (din.xo >>> STAGE);
			nxt.zo = din.zo + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule

`default_nettype wire

FILE: hdl/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// position, normal, tangent, bitangent and texture coordinates of a sphere grid
// ----------------------------------------------------------------------------
// One vertex (row, col) enters per cycle unless the output stalls; its result passes
// head_s1, the cordic cells and s2 to s5. Throughput is one transaction per cycle, set by
// the row of cordic cells, one rotation step per cell, that works the latitude and
// longitude angles side by side. The whole pipe moves only when the output register is
// empty or taken, so an output stall holds the input. The user writes lat_step and
// lon_step through cfg_en/cfg_idx/cfg_data only while idle; the block does not check it.
`default_nettype none

module uv_sphere_vertex_generator
	import uvs_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_en,
	input  wire logic         cfg_idx,
	input  wire logic [14:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [23:0]  s_axis_tdata,  // row, col
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [183:0]      m_axis_tdata   // pos_x/y/z, tan_x/y/z, bitan_x/y/z, tex_u, tex_v
);

	logic [14:0] lat_step_q, lon_step_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_step_q <= LAT_STEP_RST;
			lon_step_q <= LON_STEP_RST;
		end else if (cfg_en) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_LAT_STEP: lat_step_q <= cfg_data;
				REG_LON_STEP: lon_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: angles, fold, texture u
	logic [7:0]  row;
	logic [8:0]  col;
	logic [22:0] lat_prod;
	logic [23:0] lon_prod;
	logic [15:0] lat, lon;
	logic signed [16:0] fa, fo;
	logic        na, no;
	logic [16:0] u;

	assign row = s_axis_tdata[7:0];
	assign col = s_axis_tdata[16:8];
	assign lat_prod = row * lat_step_q;
	assign lon_prod = col * lon_step_q;
	assign lat = 16'd16384 + lat_prod[15:0];
	assign lon = 16'd32768 + lon_prod[15:0];
	assign u = (lon_prod > 24'd65536) ? 17'd65536 : lon_prod[16:0];

	always_comb begin
		fa = 17'(signed'(lat));
		na = 1'b0;
		if (fa > 17'sd16384) begin
			fa = fa - 17'sd32768;
			na = 1'b1;
		end else if (fa < -17'sd16384) begin
			fa = fa + 17'sd32768;
			na = 1'b1;
		end
		fo = 17'(signed'(lon));
		no = 1'b0;
		if (fo > 17'sd16384) begin
			fo = fo - 17'sd32768;
			no = 1'b1;
		end else if (fo < -17'sd16384) begin
			fo = fo + 17'sd32768;
			no = 1'b1;
		end
	end

	cordic_t chain [0:CORDIC_STAGES];
	cordic_t head_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s1 <= '0;
		end else if (en) begin
			head_s1.vld  <= s_axis_tvalid;
			head_s1.xa   <= CORDIC_GAIN;
			head_s1.ya   <= '0;
			head_s1.za   <= CW'(fa) <<< 16;
			head_s1.nega <= na;
			head_s1.xo   <= CORDIC_GAIN;
			head_s1.yo   <= '0;
			head_s1.zo   <= CW'(fo) <<< 16;
			head_s1.nego <= no;
			head_s1.u    <= u;
		end
	end

	assign chain[0] = head_s1;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		uvs_cell #(.STAGE(g)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.din   (chain[g]),
			.dout  (chain[g+1])
		);
	end

	cordic_t tl;
	assign tl = chain[CORDIC_STAGES];

	function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v,
		input logic n);
		logic signed [CW:0] t;
		logic signed [CW:0] r;
		t = n ? -(CW+1)'(v) : (CW+1)'(v);
		r = (t + (CW+1)'(32768)) >>> 16;
		if (r > (CW+1)'(16384))
			return ONE_Q14;
		else if (r < -(CW+1)'(16384))
			return -ONE_Q14;
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] rnd_mul(input logic signed [31:0] p);
		logic signed [31:0] r;
		r = (p + 32'sd8192) >>> 14;
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] rnd_diff(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] d;
		d = (33'(a) - 33'(b) + 33'sd8192) >>> 14;
		if (d > 33'sd16384)
			return ONE_Q14;
		else if (d < -33'sd16384)
			return -ONE_Q14;
		return d[15:0];
	endfunction

	// sin and cos
	logic vld_s2;
	logic signed [15:0] slat_s2, clat_s2, slon_s2, clon_s2;
	logic [16:0] u_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= tl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clat_s2 <= to_q14(tl.xa, tl.nega);
			slat_s2 <= to_q14(tl.ya, tl.nega);
			clon_s2 <= to_q14(tl.xo, tl.nego);
			slon_s2 <= to_q14(tl.yo, tl.nego);
			u_s2    <= tl.u;
		end
	end

	// position and tangent
	logic vld_s3;
	logic signed [15:0] px_s3, py_s3, pz_s3, tx_s3, tz_s3;
	logic signed [15:0] m1, m2;
	logic [16:0] u_s3;

	assign m1 = rnd_mul(slon_s2 * clat_s2);
	assign m2 = rnd_mul(clon_s2 * clat_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= -m1;
			py_s3 <= slat_s2;
			pz_s3 <= m2;
			tx_s3 <= -m2;
			tz_s3 <= -m1;
			u_s3  <= u_s2;
		end
	end

	// cross products
	logic vld_s4;
	logic signed [15:0] px_s4, py_s4, pz_s4, tx_s4, tz_s4;
	logic signed [31:0] pa_s4, pb_s4, pc_s4, pd_s4, pe_s4, pf_s4;
	logic [16:0] u_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4 <= py_s3 * tz_s3;
			pb_s4 <= pz_s3 * py_s3;
			pc_s4 <= pz_s3 * tx_s3;
			pd_s4 <= px_s3 * tz_s3;
			pe_s4 <= px_s3 * py_s3;
			pf_s4 <= py_s3 * tx_s3;
			px_s4 <= px_s3;
			py_s4 <= py_s3;
			pz_s4 <= pz_s3;
			tx_s4 <= tx_s3;
			tz_s4 <= tz_s3;
			u_s4  <= u_s3;
		end
	end

	// output register
	logic vld_s5;
	logic signed [15:0] px_s5, py_s5, pz_s5, tx_s5, tz_s5, bx_s5, by_s5, bz_s5, v_s5;
	logic [16:0] u_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s5 <= rnd_diff(pa_s4, pb_s4);
			by_s5 <= rnd_diff(pc_s4, pd_s4);
			bz_s5 <= rnd_diff(pe_s4, pf_s4);
			px_s5 <= px_s4;
			py_s5 <= py_s4;
			pz_s5 <= pz_s4;
			tx_s5 <= tx_s4;
			tz_s5 <= tz_s4;
			v_s5  <= py_s4 + 16'sd8192;
			u_s5  <= u_s4;
		end
	end

	assign en = !vld_s5 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata = {7'b0, v_s5, u_s5, bz_s5, by_s5, bx_s5, tz_s5, py_s5, tx_s5,
		pz_s5, py_s5, px_s5};

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output register");
	a_tan_z: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[95:80] == m_axis_tdata[15:0])
		else $error("tangent z differs from position x");
	a_tan_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63:48] == 16'(-signed'(m_axis_tdata[47:32])))
		else $error("tangent x differs from minus position z");
	a_tex_v: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[176:161] == m_axis_tdata[31:16] + 16'd8192)
		else $error("texture v differs from position y plus half");

endmodule

`default_nettype wire
